// File: rtl/brle_pkg.sv
// Shared types, constants and register map of the block run-length encoder.
`default_nettype none

package brle_pkg;

    localparam int unsigned TYPE_W      = 6;
    localparam int unsigned LEVEL_W     = 4;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned MASK_W      = 64;

    // Type codes carry TYPE_BITS significant bits inside the 6-bit field.
    localparam int unsigned TYPE_BITS   = 6;
    localparam logic [TYPE_W-1:0] CELL_TYPE_MASK = TYPE_W'((1 << TYPE_BITS) - 1);

    // Longest run that one result can carry.
    localparam logic [COUNT_W-1:0] MAX_RUN = 16'hFFFF;

    // Register file: 64-bit data, register i at byte address 8*i.
    localparam int unsigned APB_DATA_W  = 64;
    localparam int unsigned APB_ADDR_W  = 5;

    typedef enum logic [1:0] {
        REG_LIQUID_MASK  = 2'd0,
        REG_AIR_CODE     = 2'd1,
        REG_SOURCE_LEVEL = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_index;

    localparam logic [MASK_W-1:0]  RST_LIQUID_MASK  = '0;
    localparam logic [TYPE_W-1:0]  RST_AIR_CODE     = '0;
    localparam logic [LEVEL_W-1:0] RST_SOURCE_LEVEL = 4'd8;

    // Result queue depth; must hold at least two entries.
    localparam int unsigned FIFO_DEPTH  = 4;

    typedef struct packed {
        logic [TYPE_W-1:0]  cell_type;
        logic [LEVEL_W-1:0] fluid_level;
        logic               final_cell;
    } t_cell_item;

    typedef struct packed {
        logic [COUNT_W-1:0] run_count;
        logic [TYPE_W-1:0]  run_type;
        logic               final_run;
    } t_run_item;

    // Results produced by one processed cell, in output order.
    typedef struct packed {
        logic      push_first;
        logic      push_second;
        t_run_item first;
        t_run_item second;
    } t_run_push;

endpackage

`default_nettype wire

// File: rtl/brle_filter.sv
// Cell filter: replace transient liquid below the source level by the air code.
`default_nettype none

module brle_filter (
    input  wire logic [brle_pkg::TYPE_W-1:0]  i_cell_type,
    input  wire logic [brle_pkg::LEVEL_W-1:0] i_fluid_level,
    input  wire logic [brle_pkg::MASK_W-1:0]  i_liquid_mask,
    input  wire logic [brle_pkg::TYPE_W-1:0]  i_air_code,
    input  wire logic [brle_pkg::LEVEL_W-1:0] i_source_level,
    output logic      [brle_pkg::TYPE_W-1:0]  o_filt_type
);

    logic [brle_pkg::TYPE_W-1:0] type_sig;
    logic                        liquid;

    always_comb begin
        type_sig = i_cell_type & brle_pkg::CELL_TYPE_MASK;
        liquid   = i_liquid_mask[type_sig];
        if (liquid && (i_fluid_level < i_source_level)) begin
            o_filt_type = i_air_code & brle_pkg::CELL_TYPE_MASK;
        end else begin
            o_filt_type = type_sig;
        end
    end

endmodule

`default_nettype wire

// File: rtl/brle_run.sv
// Open-run state and the closing, counting and final-flush decisions.
`default_nettype none

module brle_run (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_go,
    input  wire logic [brle_pkg::TYPE_W-1:0] i_filt_type,
    input  wire logic                        i_final_cell,
    output brle_pkg::t_run_push              o_push
);

    logic [brle_pkg::TYPE_W-1:0]  r_open_type, n_open_type;
    logic [brle_pkg::COUNT_W-1:0] r_open_count, n_open_count;
    logic                         r_run_open, n_run_open;

    logic                         close_run;
    logic [brle_pkg::TYPE_W-1:0]  cur_type;
    logic [brle_pkg::COUNT_W-1:0] cur_count;
    brle_pkg::t_run_item          closed_item;
    brle_pkg::t_run_item          flush_item;

    always_comb begin
        close_run = r_run_open &&
                    ((i_filt_type != r_open_type) || (r_open_count >= brle_pkg::MAX_RUN));

        // Run as it stands once this cell has joined it.
        if (close_run || !r_run_open) begin
            cur_type  = i_filt_type;
            cur_count = brle_pkg::COUNT_W'(1);
        end else begin
            cur_type  = r_open_type;
            cur_count = r_open_count + brle_pkg::COUNT_W'(1);
        end

        closed_item.run_count = r_open_count;
        closed_item.run_type  = r_open_type;
        closed_item.final_run = 1'b0;

        flush_item.run_count  = cur_count;
        flush_item.run_type   = cur_type;
        flush_item.final_run  = 1'b1;

        o_push.push_first  = i_go && (close_run || i_final_cell);
        o_push.push_second = i_go && close_run && i_final_cell;
        o_push.first       = close_run ? closed_item : flush_item;
        o_push.second      = flush_item;

        n_open_type  = r_open_type;
        n_open_count = r_open_count;
        n_run_open   = r_run_open;
        if (i_go) begin
            if (i_final_cell) begin
                n_open_type  = '0;
                n_open_count = '0;
                n_run_open   = 1'b0;
            end else begin
                n_open_type  = cur_type;
                n_open_count = cur_count;
                n_run_open   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_type  <= '0;
            r_open_count <= '0;
            r_run_open   <= 1'b0;
        end else begin
            r_open_type  <= n_open_type;
            r_open_count <= n_open_count;
            r_run_open   <= n_run_open;
        end
    end

endmodule

`default_nettype wire

// File: rtl/brle_fifo.sv
// Result queue: takes up to two runs a cycle, hands out one a cycle while the output is not stalled.
`default_nettype none

module brle_fifo #(
    parameter int unsigned P_DEPTH = brle_pkg::FIFO_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire brle_pkg::t_run_push  i_push,
    output logic                      o_room_two,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output brle_pkg::t_run_item       o_out_item
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);

    brle_pkg::t_run_item r_store [P_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;

    logic [PTR_W-1:0]    wr_ptr_next;
    logic                pop;
    logic [1:0]          num_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        res = (ptr == LAST_PTR) ? '0 : ptr + PTR_W'(1);
        return res;
    endfunction

    always_comb begin
        wr_ptr_next = ptr_inc(r_wr_ptr);
        pop         = (r_count != '0) && !i_out_stall;
        num_push    = {1'b0, i_push.push_first} + {1'b0, i_push.push_second};

        n_wr_ptr = r_wr_ptr;
        if (i_push.push_second) begin
            n_wr_ptr = ptr_inc(wr_ptr_next);
        end else if (i_push.push_first) begin
            n_wr_ptr = wr_ptr_next;
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(num_push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_first) begin
            r_store[r_wr_ptr] <= i_push.first;
        end
        if (i_push.push_second) begin
            r_store[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_room_two  = (r_count <= CNT_W'(P_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_store[r_rd_ptr];

endmodule

`default_nettype wire

// File: rtl/block_run_length_encoder_unit.sv
// Top level of the block run-length encoder: input register, registers, run unit, queue.
// A cell accepted into the input register passes the filter and run unit once the queue
//   has room for two runs; the runs it closes or flushes are queued, then shown on o_out_valid.
// Throughput: one cell per cycle while the queue has room for two runs; runs leave the
//   queue at one per cycle while the output is not stalled.
// Reset (synchronous, active low): no open run, queue and input register empty,
//   registers back to mask 0, air code 0, source level 8.
`default_nettype none

module block_run_length_encoder_unit #(
    parameter int unsigned P_FIFO_DEPTH = brle_pkg::FIFO_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    // Cell input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire brle_pkg::t_cell_item               i_in_item,

    // Run output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output brle_pkg::t_run_item                     o_out_item,

    // Register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [brle_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [brle_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [brle_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    // ---------------------------------------------------------------
    // Configuration registers. The user writes only while the block is idle; not enforced.
    // ---------------------------------------------------------------
    logic [brle_pkg::MASK_W-1:0]  r_liquid_mask;
    logic [brle_pkg::TYPE_W-1:0]  r_air_code;
    logic [brle_pkg::LEVEL_W-1:0] r_source_level;

    brle_pkg::t_reg_index         reg_index;
    logic                         reg_write;

    assign pready    = 1'b1;
    assign reg_index = brle_pkg::t_reg_index'(paddr[4:3]);
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_liquid_mask  <= brle_pkg::RST_LIQUID_MASK;
            r_air_code     <= brle_pkg::RST_AIR_CODE;
            r_source_level <= brle_pkg::RST_SOURCE_LEVEL;
        end else if (reg_write) begin
            unique case (reg_index)
                brle_pkg::REG_LIQUID_MASK: begin
                    r_liquid_mask <= pwdata;
                end
                brle_pkg::REG_AIR_CODE: begin
                    r_air_code <= pwdata[brle_pkg::TYPE_W-1:0];
                end
                brle_pkg::REG_SOURCE_LEVEL: begin
                    r_source_level <= pwdata[brle_pkg::LEVEL_W-1:0];
                end
                default: begin
                    // unmapped slot: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            brle_pkg::REG_LIQUID_MASK:  prdata = r_liquid_mask;
            brle_pkg::REG_AIR_CODE:     prdata = brle_pkg::APB_DATA_W'(r_air_code);
            brle_pkg::REG_SOURCE_LEVEL: prdata = brle_pkg::APB_DATA_W'(r_source_level);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input register. The held cell advances into the run unit when
    // the queue has room for the two runs it may produce; otherwise
    // hold it and stall the sender.
    // ---------------------------------------------------------------
    logic                 r_in_valid, n_in_valid;
    brle_pkg::t_cell_item r_in_item;
    logic                 room_two;
    logic                 go;
    logic                 in_accept;

    assign go         = r_in_valid && room_two;
    assign o_in_stall = r_in_valid && !room_two;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload needs no reset: it is only looked at behind r_in_valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // ---------------------------------------------------------------
    // Filter, then run tracking: one short combinational pass.
    // ---------------------------------------------------------------
    logic [brle_pkg::TYPE_W-1:0] filt_type;
    brle_pkg::t_run_push         run_push;

    brle_filter u_filter (
        .i_cell_type    (r_in_item.cell_type),
        .i_fluid_level  (r_in_item.fluid_level),
        .i_liquid_mask  (r_liquid_mask),
        .i_air_code     (r_air_code),
        .i_source_level (r_source_level),
        .o_filt_type    (filt_type)
    );

    brle_run u_run (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_filt_type  (filt_type),
        .i_final_cell (r_in_item.final_cell),
        .o_push       (run_push)
    );

    // ---------------------------------------------------------------
    // Result queue: decouples the output stall from cell intake.
    // ---------------------------------------------------------------
    brle_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (run_push),
        .o_room_two  (room_two),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: rtl/brle_checker.sv
// Port-level checks of the block run-length encoder, bound to its top level.
`default_nettype none

module brle_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire brle_pkg::t_run_item  o_out_item
);

    // Reset empties the queue.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Every emitted run holds at least one cell.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.run_count != '0))
        else $error("run of zero cells emitted");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    // Stall towards the sender only while a cell is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ($past(i_in_valid && !o_in_stall) || $past(o_in_stall)))
        else $error("input stalled with no cell held");

endmodule

bind block_run_length_encoder_unit brle_checker u_brle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
